[src/shar_pkg.sv]
// ---------------------------------------------------------------------------
// shar_pkg: types and constants for the SCSI host adapter register block
// Register offsets, CSR bits and beat payload structs.
// ---------------------------------------------------------------------------
package shar_pkg;

    localparam int UDC_DEPTH = 64;
    localparam int UDC_AW    = $clog2(UDC_DEPTH);

    localparam logic [5:0]  UDC_START_IDX = 6'h2E;
    localparam logic [15:0] UDC_START_CMD = 16'h00A0;
    localparam logic [7:0]  UDC_START_HI  = 8'hA0;
    localparam logic [15:0] CSR_WR_MASK   = 16'h001F;
    localparam logic [7:0]  RD_UNMAPPED   = 8'hFF;

    localparam logic [15:0] CSR_RESET_CTRL = 16'h0001;
    localparam logic [15:0] CSR_INT_ENABLE = 16'h0004;
    localparam logic [15:0] CSR_INT_DMA    = 16'h0100;
    localparam logic [15:0] CSR_INT_CHIP   = 16'h0200;
    localparam logic [15:0] CSR_FIFO_EMPTY = 16'h0400;
    localparam logic [15:0] CSR_BUS_ERROR  = 16'h2000;
    localparam logic [15:0] CSR_CONFLICT   = 16'h4000;

    localparam logic [4:0] OFF_DATA    = 5'h00;
    localparam logic [4:0] OFF_ICMD    = 5'h01;
    localparam logic [4:0] OFF_MODE    = 5'h02;
    localparam logic [4:0] OFF_TCMD    = 5'h03;
    localparam logic [4:0] OFF_BSTAT   = 5'h04;
    localparam logic [4:0] OFF_BAS     = 5'h05;
    localparam logic [4:0] OFF_IDATA   = 5'h06;
    localparam logic [4:0] OFF_RPI     = 5'h07;
    localparam logic [4:0] OFF_DADDR0  = 5'h08;
    localparam logic [4:0] OFF_DADDR3  = 5'h0B;
    localparam logic [4:0] OFF_DLEN0   = 5'h0C;
    localparam logic [4:0] OFF_DLEN3   = 5'h0F;
    localparam logic [4:0] OFF_UDATA_H = 5'h10;
    localparam logic [4:0] OFF_UDATA_L = 5'h11;
    localparam logic [4:0] OFF_UPTR_H  = 5'h12;
    localparam logic [4:0] OFF_UPTR_L  = 5'h13;
    localparam logic [4:0] OFF_FIFO_H  = 5'h16;
    localparam logic [4:0] OFF_FIFO_L  = 5'h17;
    localparam logic [4:0] OFF_CSR_H   = 5'h18;
    localparam logic [4:0] OFF_CSR_L   = 5'h19;

    localparam logic [1:0] ARB_IDLE   = 2'd0;
    localparam logic [1:0] ARB_ARMING = 2'd1;
    localparam logic [1:0] ARB_SEEN   = 2'd2;

    typedef struct packed {
        logic        command;
        logic [4:0]  offset;
        logic [15:0] write_data;
        logic        wide_access;
        logic        phase_valid;
        logic [2:0]  target_phase;
        logic        target_req;
        logic        target_bsy;
        logic [7:0]  bus_data;
    } shar_in_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        irq_level;
        logic        drive_bsy;
        logic        drive_sel;
        logic        drive_ack;
        logic        drive_atn;
        logic        drive_rst;
        logic [7:0]  drive_data;
        logic        bus_reset_pulse;
        logic        chain_start_pulse;
    } shar_out_t;

endpackage

[src/scsi_host_adapter_registers_top.sv]
// ---------------------------------------------------------------------------
// scsi_host_adapter_registers_top: SCSI host adapter register window
// Chip registers, DMA address/count, indirect DMA controller file, CSR.
// ---------------------------------------------------------------------------
// One bus access per beat; a new beat is taken every cycle while the output
// is not stalled and no file clear runs. The access is registered at the
// input, then decoded and applied, and its result beat lands in an output
// register. The 64-entry DMA controller file is a memory with a registered
// read port: it is read ahead at the pointer value that the current access
// leaves, with a bypass for a store to that entry. Reset clears the file by a
// sweep over all 64 entries during which no beat is accepted.
// ---------------------------------------------------------------------------
module scsi_host_adapter_registers_top import shar_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  shar_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output shar_out_t m_data
);

    // pipeline control
    logic      in_vld_reg;
    shar_in_t  in_reg;
    logic      out_vld_reg;
    shar_out_t out_reg;
    logic      adv;
    logic      clr_busy_reg;
    logic [UDC_AW-1:0] clr_idx_reg;

    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = adv && !clr_busy_reg;
    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    // architectural state
    logic [7:0]  icmd_reg, mode_reg, tcmd_reg, sel_en_reg, odata_reg;
    logic [15:0] csr_reg, latch_reg, uptr_reg, fifo_reg;
    logic [31:0] daddr_reg, dlen_reg;
    logic [1:0]  arb_reg;
    logic        f_chip_reg, f_end_reg, f_pend_reg, f_irq_reg;
    logic        f_preq_reg, f_pien_reg, f_pdma_reg;

    logic [15:0] udc_mem [UDC_DEPTH];
    logic [15:0] mem_rd_reg;
    logic        byp_reg;
    logic [15:0] byp_data_reg;

    // next-state values
    logic [7:0]  icmd_next, mode_next, tcmd_next, sel_en_next, odata_next;
    logic [15:0] csr_next, latch_next, uptr_next, fifo_next;
    logic [31:0] daddr_next, dlen_next;
    logic [1:0]  arb_next;
    logic        f_chip_next, f_end_next, f_pend_next, f_irq_next;
    logic        f_preq_next, f_pien_next, f_pdma_next;
    logic        st_en;
    logic [15:0] rd;
    logic        rst_p, chain_p;
    logic [15:0] ent;
    logic        bvalid, breq;
    logic [1:0]  bsh;

    assign ent = byp_reg ? byp_data_reg : mem_rd_reg;

    always_comb begin
        icmd_next = icmd_reg; mode_next = mode_reg; tcmd_next = tcmd_reg;
        sel_en_next = sel_en_reg; odata_next = odata_reg;
        csr_next = csr_reg; latch_next = latch_reg; uptr_next = uptr_reg;
        fifo_next = fifo_reg; daddr_next = daddr_reg; dlen_next = dlen_reg;
        arb_next = arb_reg;
        f_chip_next = f_chip_reg; f_end_next = f_end_reg; f_pend_next = f_pend_reg;
        f_irq_next = f_irq_reg; f_preq_next = f_preq_reg; f_pien_next = f_pien_reg;
        f_pdma_next = f_pdma_reg;
        st_en = 1'b0; rd = 16'h0; rst_p = 1'b0; chain_p = 1'b0;
        bvalid = in_reg.phase_valid; breq = in_reg.target_req;
        bsh = 2'd3 - in_reg.offset[1:0];

        if (in_reg.command) begin
            case (in_reg.offset)
                OFF_DATA:  odata_next = in_reg.write_data[7:0];
                OFF_ICMD:  icmd_next = in_reg.write_data[7:0];
                OFF_MODE: begin
                    mode_next = in_reg.write_data[7:0];
                    if (!mode_reg[0] && mode_next[0]) arb_next = ARB_ARMING;
                    else if (mode_reg[0] && !mode_next[0]) arb_next = ARB_IDLE;
                end
                OFF_TCMD:  tcmd_next = in_reg.write_data[7:0];
                OFF_BSTAT: sel_en_next = in_reg.write_data[7:0];
                OFF_UDATA_H: begin
                    if (in_reg.wide_access) begin
                        latch_next = in_reg.write_data;
                        st_en = 1'b1;
                    end else begin
                        latch_next = {in_reg.write_data[7:0], latch_reg[7:0]};
                    end
                end
                OFF_UDATA_L: begin
                    latch_next = {latch_reg[15:8], in_reg.write_data[7:0]};
                    st_en = 1'b1;
                end
                OFF_UPTR_H: uptr_next = in_reg.wide_access ? in_reg.write_data
                                        : {in_reg.write_data[7:0], uptr_reg[7:0]};
                OFF_UPTR_L: uptr_next = {uptr_reg[15:8], in_reg.write_data[7:0]};
                OFF_FIFO_H: fifo_next = in_reg.wide_access ? in_reg.write_data
                                        : {in_reg.write_data[7:0], fifo_reg[7:0]};
                OFF_FIFO_L: fifo_next = {fifo_reg[15:8], in_reg.write_data[7:0]};
                OFF_CSR_H, OFF_CSR_L: begin
                    if (in_reg.offset == OFF_CSR_L || in_reg.wide_access) begin
                        csr_next = (csr_reg & ~CSR_WR_MASK)
                                 | (in_reg.write_data & CSR_WR_MASK);
                        if (csr_reg[0] && !csr_next[0]) begin
                            icmd_next = 8'h0; mode_next = 8'h0; tcmd_next = 8'h0;
                            csr_next = (csr_next & ~(CSR_INT_DMA | CSR_INT_CHIP
                                       | CSR_BUS_ERROR | CSR_CONFLICT)) | CSR_FIFO_EMPTY;
                            f_chip_next = 1'b0; f_end_next = 1'b0;
                            bvalid = 1'b0; breq = 1'b0;
                            rst_p = 1'b1;
                        end
                    end
                end
                default: begin
                    if (in_reg.offset >= OFF_DADDR0 && in_reg.offset <= OFF_DADDR3)
                        daddr_next[{bsh, 3'b000} +: 8] = in_reg.write_data[7:0];
                    else if (in_reg.offset >= OFF_DLEN0 && in_reg.offset <= OFF_DLEN3)
                        dlen_next[{bsh, 3'b000} +: 8] = in_reg.write_data[7:0];
                end
            endcase
            if (st_en && uptr_reg[UDC_AW-1:0] == UDC_START_IDX
                && (latch_next == UDC_START_CMD || latch_next[15:8] == UDC_START_HI)) begin
                fifo_next = 16'h0;
                csr_next = (csr_next | CSR_FIFO_EMPTY) & ~CSR_BUS_ERROR;
                f_pend_next = 1'b1;
                chain_p = 1'b1;
            end
        end else begin
            case (in_reg.offset)
                OFF_DATA, OFF_IDATA: rd = {8'h0, in_reg.bus_data};
                OFF_ICMD: begin
                    rd = {8'h0, icmd_reg};
                    if (mode_reg[0] && arb_reg == ARB_ARMING) begin
                        rd[6] = 1'b1;
                        arb_next = ARB_SEEN;
                    end
                end
                OFF_MODE: rd = {8'h0, mode_reg};
                OFF_TCMD: rd = {8'h0, tcmd_reg};
                OFF_BSTAT: begin
                    rd[4:2] = bvalid ? in_reg.target_phase : 3'd0;
                    rd[1] = icmd_reg[2] && !icmd_reg[3];
                    rd[6] = in_reg.target_bsy;
                    rd[5] = breq;
                end
                OFF_BAS: begin
                    rd[7] = f_end_reg;
                    rd[6] = breq;
                    rd[3] = tcmd_reg[2:0] == (bvalid ? in_reg.target_phase : 3'd0);
                    rd[1] = icmd_reg[1];
                    rd[0] = icmd_reg[4];
                end
                OFF_RPI: begin
                    f_chip_next = 1'b0; f_end_next = 1'b0;
                    csr_next = csr_reg & ~(CSR_INT_CHIP | CSR_INT_DMA);
                end
                OFF_UDATA_H: rd = {8'h0, ent[15:8]};
                OFF_UDATA_L: rd = {8'h0, ent[7:0]};
                OFF_UPTR_H:  rd = {8'h0, uptr_reg[15:8]};
                OFF_UPTR_L:  rd = {8'h0, uptr_reg[7:0]};
                OFF_FIFO_H:  rd = {8'h0, fifo_reg[15:8]};
                OFF_FIFO_L:  rd = {8'h0, fifo_reg[7:0]};
                OFF_CSR_H, OFF_CSR_L: begin
                    if (f_pend_reg) begin
                        f_pend_next = 1'b0;
                        csr_next = csr_reg | CSR_INT_CHIP | CSR_FIFO_EMPTY;
                        f_chip_next = 1'b1; f_end_next = 1'b1;
                    end
                    if (in_reg.offset == OFF_CSR_L) rd = {8'h0, csr_next[7:0]};
                    else rd = in_reg.wide_access ? csr_next : {8'h0, csr_next[15:8]};
                end
                default: begin
                    if (in_reg.offset >= OFF_DADDR0 && in_reg.offset <= OFF_DADDR3)
                        rd = {8'h0, daddr_reg[{bsh, 3'b000} +: 8]};
                    else if (in_reg.offset >= OFF_DLEN0 && in_reg.offset <= OFF_DLEN3)
                        rd = {8'h0, dlen_reg[{bsh, 3'b000} +: 8]};
                    else rd = {8'h0, RD_UNMAPPED};
                end
            endcase
        end

        // phase-mismatch edge detect, on the accesses that sample it
        if ((in_reg.command && (in_reg.offset <= OFF_BSTAT || in_reg.offset == OFF_CSR_L
             || (in_reg.offset == OFF_CSR_H && in_reg.wide_access)))
            || (!in_reg.command && (in_reg.offset == OFF_BSTAT || in_reg.offset == OFF_BAS)))
        begin
            if (!(in_reg.command && in_reg.offset == OFF_MODE)
                || (!mode_reg[1] && mode_next[1])) begin
                f_preq_next = breq;
                f_pien_next = csr_next[2];
                if (bvalid && csr_next[2] && breq
                    && in_reg.target_phase != tcmd_next[2:0]) begin
                    f_pdma_next = mode_next[1];
                    if (((breq && !f_preq_reg) || (csr_next[2] && !f_pien_reg)
                         || (mode_next[1] && !f_pdma_reg))
                        && (mode_next[1] || sel_en_next != 8'h0)) begin
                        csr_next = csr_next | CSR_INT_CHIP;
                        f_chip_next = 1'b1;
                    end
                end
            end
        end

        // status read shows a chip interrupt raised by its own edge detect
        if (!in_reg.command && in_reg.offset == OFF_BAS) rd[4] = f_chip_next;

        // the irq line is recomputed by the accesses that touch interrupt state
        if (f_chip_next != f_chip_reg || csr_next != csr_reg || chain_p
            || (in_reg.command && (in_reg.offset == OFF_CSR_L
                || (in_reg.offset == OFF_CSR_H && in_reg.wide_access)))
            || (!in_reg.command && (in_reg.offset == OFF_RPI
                || in_reg.offset == OFF_CSR_H || in_reg.offset == OFF_CSR_L)))
            f_irq_next = csr_next[2] && (csr_next[8] || csr_next[9] || csr_next[13]);
    end

    // file memory: read address looks ahead to the pointer after this beat
    logic [UDC_AW-1:0] rd_addr;
    logic              mem_we;
    logic [UDC_AW-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              work;

    assign work    = in_vld_reg && adv;
    assign rd_addr = work ? uptr_next[UDC_AW-1:0] : uptr_reg[UDC_AW-1:0];
    assign mem_we  = clr_busy_reg || (work && st_en);
    assign wr_addr = clr_busy_reg ? clr_idx_reg : uptr_reg[UDC_AW-1:0];
    assign wr_data = clr_busy_reg ? 16'h0 : latch_next;

    always_ff @(posedge aclk) begin
        if (mem_we) udc_mem[wr_addr] <= wr_data;
        mem_rd_reg   <= udc_mem[rd_addr];
        byp_reg      <= mem_we && wr_addr == rd_addr;
        byp_data_reg <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0; out_vld_reg <= 1'b0;
            clr_busy_reg <= 1'b1; clr_idx_reg <= '0;
            icmd_reg <= 8'h0; mode_reg <= 8'h0; tcmd_reg <= 8'h0;
            sel_en_reg <= 8'h0; odata_reg <= 8'h0;
            csr_reg <= CSR_FIFO_EMPTY; latch_reg <= 16'h0; uptr_reg <= 16'h0;
            fifo_reg <= 16'h0; daddr_reg <= 32'h0; dlen_reg <= 32'h0;
            arb_reg <= ARB_IDLE;
            f_chip_reg <= 1'b0; f_end_reg <= 1'b0; f_pend_reg <= 1'b0;
            f_irq_reg <= 1'b0; f_preq_reg <= 1'b0; f_pien_reg <= 1'b0;
            f_pdma_reg <= 1'b0;
        end else begin
            if (clr_busy_reg) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (&clr_idx_reg) clr_busy_reg <= 1'b0;
            end
            if (adv) begin
                in_vld_reg  <= s_valid && s_ready;
                out_vld_reg <= in_vld_reg;
            end
            if (s_valid && s_ready) in_reg <= s_data;
            if (work) begin
                icmd_reg <= icmd_next; mode_reg <= mode_next; tcmd_reg <= tcmd_next;
                sel_en_reg <= sel_en_next; odata_reg <= odata_next;
                csr_reg <= csr_next; latch_reg <= latch_next; uptr_reg <= uptr_next;
                fifo_reg <= fifo_next; daddr_reg <= daddr_next; dlen_reg <= dlen_next;
                arb_reg <= arb_next;
                f_chip_reg <= f_chip_next; f_end_reg <= f_end_next;
                f_pend_reg <= f_pend_next; f_irq_reg <= f_irq_next;
                f_preq_reg <= f_preq_next; f_pien_reg <= f_pien_next;
                f_pdma_reg <= f_pdma_next;
                out_reg.read_data         <= rd;
                out_reg.irq_level         <= f_irq_next;
                out_reg.drive_bsy         <= icmd_next[3];
                out_reg.drive_sel         <= icmd_next[2] && !icmd_next[3];
                out_reg.drive_ack         <= icmd_next[4];
                out_reg.drive_atn         <= icmd_next[1];
                out_reg.drive_rst         <= icmd_next[7];
                out_reg.drive_data        <= odata_next;
                out_reg.bus_reset_pulse   <= rst_p;
                out_reg.chain_start_pulse <= chain_p;
            end
        end
    end

    // checks
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_ready) else $error("beat taken during file clear");
    a_sel_gated: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.drive_sel && m_data.drive_bsy))
        else $error("SEL driven with BSY");
    a_reset_pulse_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.bus_reset_pulse) |-> (m_data.read_data == 16'h0
            && !m_data.drive_bsy && !m_data.drive_ack))
        else $error("bus reset left initiator lines");
    a_irq_needs_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        f_irq_reg |-> csr_reg[2]) else $error("irq without enable");

endmodule
